FILE: design/page_frame_bitmap_allocator_core_defines.svh
// Assertion macros shared by the page frame allocator RTL.
`ifndef PAGE_FRAME_BITMAP_ALLOCATOR_CORE_DEFINES_SVH
`define PAGE_FRAME_BITMAP_ALLOCATOR_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFBA_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PFBA_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/pfba_pkg.sv
// Shared constants, types and helper functions of the page frame allocator.
package pfba_pkg;

  localparam int MAX_PAGES  = 4096;
  localparam int PAGE_BYTES = 4096;

  localparam int ADDR_W    = 32;
  localparam int PAGE_BITS = $clog2(PAGE_BYTES);
  localparam int PN_W      = ADDR_W - PAGE_BITS;
  localparam int WORD_BITS = 64;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int ROWS      = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ROWS_P2   = 1 << ROW_W;
  localparam int IDX_W     = ROW_W + BIT_W;
  localparam int PG_W      = $clog2(MAX_PAGES + 1);
  localparam int RCNT_W    = $clog2(ROWS + 1);
  localparam int MEM_ROWS  = 2 * ROWS_P2;
  localparam int MEM_AW    = ROW_W + 1;

  localparam int CMD_W       = 3;
  localparam int STATUS_W    = 3;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_DATA_W  = 32;
  localparam int APB_AW      = 4;
  localparam int CFG_REGS    = 4;

  localparam logic [CMD_W-1:0] CMD_EXISTS   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RESERVED = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RESERVE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FREE     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ALLOC    = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK               = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND        = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ALREADY_RESERVED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ALREADY_FREE     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISALIGNED       = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NO_FRAME         = 3'd5;

  localparam logic [1:0] CFG_A_START = 2'd0;
  localparam logic [1:0] CFG_A_LEN   = 2'd1;
  localparam logic [1:0] CFG_B_START = 2'd2;
  localparam logic [1:0] CFG_B_LEN   = 2'd3;

  // Region B is searched first, so it takes the lower half of the bitmap memory.
  localparam logic REG_B = 1'b0;
  localparam logic REG_A = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOCATE,
    S_MODIFY,
    S_SCAN,
    S_PICK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [PN_W:0]     spn;    // first page number, may equal 2^PN_W
    logic [PG_W-1:0]   pages;
    logic [RCNT_W-1:0] rows;   // bitmap words that hold pages
  } geo_t;

  typedef struct packed {
    logic                 rd_en;
    logic                 wr_en;
    logic [MEM_AW-1:0]    addr;
    logic [WORD_BITS-1:0] wdata;
  } mem_req_t;

  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

  function automatic logic [ROW_W-1:0] first_row(input logic [ROWS-1:0] v);
    logic [ROW_W-1:0] r;
    r = '0;
    for (int i = ROWS - 1; i >= 0; i--) begin
      if (v[i]) r = ROW_W'(i);
    end
    return r;
  endfunction

endpackage

FILE: design/pfba_ram.sv
// Single-port synchronous RAM with registered read data.
module pfba_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 64,
  parameter int AW    = 7
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      q <= mem[addr];
    end
  end

endmodule

FILE: design/pfba_cfg.sv
// Region registers on the APB port and the derived page geometry of both regions.
module pfba_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pfba_pkg::APB_AW-1:0]      paddr,
  input  logic [pfba_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [pfba_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready,
  output pfba_pkg::geo_t                   geo_b,
  output pfba_pkg::geo_t                   geo_a,
  output logic                             clear
);

  localparam int PB  = pfba_pkg::PAGE_BITS;
  localparam int PNW = pfba_pkg::PN_W;
  localparam int PGW = pfba_pkg::PG_W;

  logic [pfba_pkg::CFG_DATA_W-1:0] regs [pfba_pkg::CFG_REGS];
  logic                            wr;

  // Round the start up to a page, drop the skipped bytes from the length, keep whole
  // pages, and cap the count by the table size and by the top of the address space.
  function automatic pfba_pkg::geo_t shape(input logic [31:0] start, input logic [31:0] len);
    logic           rem_nz;
    logic [PB:0]    skip;
    logic [PNW:0]   spn;
    logic [PNW:0]   room;
    logic [PNW:0]   raw;
    logic [PNW:0]   lim;
    logic [31:0]    net;
    logic [PGW:0]   rsum;
    pfba_pkg::geo_t g;
    rem_nz = |start[PB-1:0];
    spn    = {1'b0, start[31:PB]} + (PNW+1)'(rem_nz);
    skip   = rem_nz ? ((PB+1)'(pfba_pkg::PAGE_BYTES) - {1'b0, start[PB-1:0]}) : '0;
    net    = len - 32'(skip);
    raw    = (len >= 32'(skip)) ? {1'b0, net[31:PB]} : '0;
    room   = {1'b1, {PNW{1'b0}}} - spn;
    lim    = (raw < room) ? raw : room;
    if (lim > (PNW+1)'(pfba_pkg::MAX_PAGES)) begin
      lim = (PNW+1)'(pfba_pkg::MAX_PAGES);
    end
    g.spn   = spn;
    g.pages = PGW'(lim);
    rsum    = {1'b0, g.pages} + (PGW+1)'(pfba_pkg::WORD_BITS - 1);
    g.rows  = pfba_pkg::RCNT_W'(rsum >> pfba_pkg::BIT_W);
    return g;
  endfunction

  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign prdata = regs[paddr[3:2]];
  // Any region write empties both bitmaps at the same edge.
  assign clear  = wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < pfba_pkg::CFG_REGS; i++) begin
        regs[i] <= '0;
      end
      geo_b <= '0;
      geo_a <= '0;
    end else begin
      if (wr) begin
        regs[paddr[3:2]] <= pwdata;
      end
      geo_b <= shape(regs[pfba_pkg::CFG_B_START], regs[pfba_pkg::CFG_B_LEN]);
      geo_a <= shape(regs[pfba_pkg::CFG_A_START], regs[pfba_pkg::CFG_A_LEN]);
    end
  end

endmodule

FILE: design/pfba_map.sv
// Used-bit store: bitmap RAM plus per-word valid and full flags.
module pfba_map (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                clear,
  input  pfba_pkg::mem_req_t                  req,
  output logic [pfba_pkg::WORD_BITS-1:0]      rdata,
  output logic [pfba_pkg::MEM_ROWS-1:0]       full
);

  logic [pfba_pkg::MEM_ROWS-1:0]  valid;
  logic                           rd_ok;
  logic [pfba_pkg::WORD_BITS-1:0] q;

  pfba_ram #(
    .DEPTH (pfba_pkg::MEM_ROWS),
    .WIDTH (pfba_pkg::WORD_BITS),
    .AW    (pfba_pkg::MEM_AW)
  ) u_ram (
    .clk   (clk),
    .we    (req.wr_en),
    .re    (req.rd_en),
    .addr  (req.addr),
    .wdata (req.wdata),
    .q     (q)
  );

  // A word never written since the last clear reads as all free.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= '0;
      full  <= '0;
    end else if (req.wr_en) begin
      valid[req.addr] <= 1'b1;
      full[req.addr]  <= &req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_ok <= valid[req.addr];
    end
  end

  assign rdata = rd_ok ? q : '0;

endmodule

FILE: design/pfba_ctrl.sv
// Command sequencer: locates pages, runs read-modify-write and the allocation search.
`include "page_frame_bitmap_allocator_core_defines.svh"

module pfba_ctrl (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [pfba_pkg::IN_TDATA_W-1:0]      s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [pfba_pkg::OUT_TDATA_W-1:0]     m_tdata,
  input  pfba_pkg::geo_t                       geo_b,
  input  pfba_pkg::geo_t                       geo_a,
  output pfba_pkg::mem_req_t                   req,
  input  logic [pfba_pkg::WORD_BITS-1:0]       rdata,
  input  logic [pfba_pkg::MEM_ROWS-1:0]        full
);

  localparam int PNW = pfba_pkg::PN_W;
  localparam int IW  = pfba_pkg::IDX_W;
  localparam int BW  = pfba_pkg::BIT_W;

  pfba_pkg::state_t                  state, state_next;
  logic [pfba_pkg::CMD_W-1:0]        cmd, cmd_next;
  logic [pfba_pkg::ADDR_W-1:0]       addr, addr_next;
  logic                              region, region_next;
  logic [IW-1:0]                     idx, idx_next;
  logic [pfba_pkg::STATUS_W-1:0]     status, status_next;
  logic                              answer, answer_next;
  logic [pfba_pkg::ADDR_W-1:0]       frame, frame_next;
  logic                              out_valid;
  logic [pfba_pkg::OUT_TDATA_W-1:0]  out_data;
  logic                              out_load;

  pfba_pkg::geo_t                    g_cur;
  logic [PNW-1:0]                    apn;
  logic [PNW:0]                      off_b, off_a;
  logic                              hit_b, hit_a, loc_hit, loc_reg;
  logic [IW-1:0]                     loc_idx;
  logic                              misaligned;
  logic [pfba_pkg::ROWS-1:0]         full_reg, rowmask, cand;
  logic [BW-1:0]                     pick_bit;
  logic [IW-1:0]                     pick_idx;
  logic                              pick_ok;
  logic [PNW:0]                      frame_pn;
  logic                              cur_bit;

  assign g_cur = (region == pfba_pkg::REG_A) ? geo_a : geo_b;

  // Page lookup against both regions; region B wins where they overlap.
  assign apn     = addr[pfba_pkg::ADDR_W-1:pfba_pkg::PAGE_BITS];
  assign off_b   = {1'b0, apn} - geo_b.spn;
  assign off_a   = {1'b0, apn} - geo_a.spn;
  assign hit_b   = ({1'b0, apn} >= geo_b.spn) && (off_b < (PNW+1)'(geo_b.pages));
  assign hit_a   = ({1'b0, apn} >= geo_a.spn) && (off_a < (PNW+1)'(geo_a.pages));
  assign loc_hit = hit_b | hit_a;
  assign loc_reg = hit_b ? pfba_pkg::REG_B : pfba_pkg::REG_A;
  assign loc_idx = hit_b ? IW'(off_b) : IW'(off_a);

  assign misaligned = |addr[pfba_pkg::PAGE_BITS-1:0];

  // Search: the first word of the region that holds pages and is not full.
  assign full_reg = (region == pfba_pkg::REG_A) ? full[pfba_pkg::ROWS_P2 +: pfba_pkg::ROWS]
                                                : full[0 +: pfba_pkg::ROWS];
  always_comb begin
    for (int w = 0; w < pfba_pkg::ROWS; w++) begin
      rowmask[w] = pfba_pkg::RCNT_W'(w) < g_cur.rows;
    end
  end
  assign cand = ~full_reg & rowmask;

  assign pick_bit = pfba_pkg::lowest_set(~rdata);
  assign pick_idx = {idx[IW-1:BW], pick_bit};
  assign pick_ok  = 32'(pick_idx) < 32'(g_cur.pages);
  assign frame_pn = g_cur.spn + (PNW+1)'(pick_idx);
  assign cur_bit  = rdata[idx[BW-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pfba_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd    <= cmd_next;
    addr   <= addr_next;
    region <= region_next;
    idx    <= idx_next;
    status <= status_next;
    answer <= answer_next;
    frame  <= frame_next;
    if (out_load) begin
      out_data <= {4'b0, frame, answer, status};
    end
  end

  always_comb begin
    state_next  = state;
    cmd_next    = cmd;
    addr_next   = addr;
    region_next = region;
    idx_next    = idx;
    status_next = status;
    answer_next = answer;
    frame_next  = frame;
    s_tready    = 1'b0;
    out_load    = 1'b0;
    req         = '0;

    case (state)
      pfba_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd_next   = s_tdata[2:0];
          addr_next  = s_tdata[34:3];
          state_next = pfba_pkg::S_LOCATE;
        end
      end

      pfba_pkg::S_LOCATE: begin
        status_next = pfba_pkg::ST_OK;
        answer_next = 1'b0;
        frame_next  = '0;
        state_next  = pfba_pkg::S_DONE;
        if (cmd <= pfba_pkg::CMD_FREE && misaligned) begin
          status_next = pfba_pkg::ST_MISALIGNED;
        end else begin
          case (cmd)
            pfba_pkg::CMD_EXISTS: begin
              answer_next = loc_hit;
            end
            pfba_pkg::CMD_RESERVED, pfba_pkg::CMD_RESERVE, pfba_pkg::CMD_FREE: begin
              if (loc_hit) begin
                region_next = loc_reg;
                idx_next    = loc_idx;
                req.rd_en   = 1'b1;
                req.addr    = {loc_reg, loc_idx[IW-1:BW]};
                state_next  = pfba_pkg::S_MODIFY;
              end else if (cmd == pfba_pkg::CMD_RESERVED) begin
                // A page outside both regions counts as reserved.
                answer_next = 1'b1;
              end else begin
                status_next = pfba_pkg::ST_NOT_FOUND;
              end
            end
            pfba_pkg::CMD_ALLOC: begin
              region_next = pfba_pkg::REG_B;
              state_next  = pfba_pkg::S_SCAN;
            end
            default: begin
            end
          endcase
        end
      end

      pfba_pkg::S_MODIFY: begin
        state_next = pfba_pkg::S_DONE;
        req.addr   = {region, idx[IW-1:BW]};
        case (cmd)
          pfba_pkg::CMD_RESERVED: begin
            answer_next = cur_bit;
          end
          pfba_pkg::CMD_RESERVE: begin
            if (cur_bit) begin
              status_next = pfba_pkg::ST_ALREADY_RESERVED;
            end else begin
              req.wr_en = 1'b1;
              req.wdata = rdata | (pfba_pkg::WORD_BITS'(1) << idx[BW-1:0]);
            end
          end
          pfba_pkg::CMD_FREE: begin
            if (!cur_bit) begin
              status_next = pfba_pkg::ST_ALREADY_FREE;
            end else begin
              req.wr_en = 1'b1;
              req.wdata = rdata & ~(pfba_pkg::WORD_BITS'(1) << idx[BW-1:0]);
            end
          end
          default: begin
          end
        endcase
      end

      pfba_pkg::S_SCAN: begin
        if (|cand) begin
          idx_next   = {pfba_pkg::first_row(cand), {BW{1'b0}}};
          req.rd_en  = 1'b1;
          req.addr   = {region, pfba_pkg::first_row(cand)};
          state_next = pfba_pkg::S_PICK;
        end else if (region == pfba_pkg::REG_B) begin
          region_next = pfba_pkg::REG_A;
        end else begin
          status_next = pfba_pkg::ST_NO_FRAME;
          state_next  = pfba_pkg::S_DONE;
        end
      end

      pfba_pkg::S_PICK: begin
        req.addr = {region, idx[IW-1:BW]};
        if (pick_ok) begin
          req.wr_en   = 1'b1;
          req.wdata   = rdata | (pfba_pkg::WORD_BITS'(1) << pick_bit);
          frame_next  = {frame_pn[PNW-1:0], {pfba_pkg::PAGE_BITS{1'b0}}};
          status_next = pfba_pkg::ST_OK;
          state_next  = pfba_pkg::S_DONE;
        end else if (region == pfba_pkg::REG_B) begin
          // The lowest free bit lies past the region's last page: try region A.
          region_next = pfba_pkg::REG_A;
          state_next  = pfba_pkg::S_SCAN;
        end else begin
          status_next = pfba_pkg::ST_NO_FRAME;
          state_next  = pfba_pkg::S_DONE;
        end
      end

      pfba_pkg::S_DONE: begin
        if (!out_valid || m_tready) begin
          out_load   = 1'b1;
          state_next = pfba_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = pfba_pkg::S_IDLE;
      end
    endcase
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  `PFBA_ASSERT_IMP(a_wr_in_update, clk, rst, req.wr_en, state == pfba_pkg::S_MODIFY || state == pfba_pkg::S_PICK, "bitmap written outside an update step")
  `PFBA_ASSERT_IMP(a_no_rd_wr, clk, rst, req.wr_en, !req.rd_en, "bitmap read and written in one cycle")
  `PFBA_ASSERT_NXT(a_accept_locate, clk, rst, s_tvalid && s_tready, state == pfba_pkg::S_LOCATE, "accepted beat not followed by lookup")
  `PFBA_ASSERT_IMP(a_frame_aligned, clk, rst, out_valid, out_data[pfba_pkg::PAGE_BITS+3:4] == '0, "frame address not page aligned")

endmodule

FILE: design/page_frame_bitmap_allocator_core.sv
// Page frame allocator top level: register port, bitmap store and command sequencer.
//
// Two physical regions of 4 KiB pages, each with one used bit per page held in a
// single-port bitmap RAM of 64-bit words (region B in the lower half, region A in
// the upper half). A command occupies the block from the beat it is accepted until
// its result is moved to the output register, and the next beat can be taken the
// cycle after that. Exists queries, misaligned or unknown commands and reserved
// queries, reserve and free of a page outside both regions go from lookup straight
// to the result. Reserved queries, reserve and free of a page inside a region go
// through lookup, RAM read, then modify and write back. Allocate scans region B for
// a word that is not full, reads it and takes its lowest free bit. When region B
// has no word with a free bit, region A is scanned instead; when the lowest free
// bit of region B's first open word lies past its last page, region A is then
// scanned. An allocate that finds nothing takes the same paths. A finished result
// waits while an earlier result still sits in the output register. The sequencer
// handles one command at a time and reads the bitmap RAM with registered read data;
// a flag per word marks full words so that the search finds the first word that is
// not full in one step. Per-word valid flags make the bitmaps read as all free
// straight after reset or a region write, with no clearing pass. Results wait in an
// output register, so the next command is accepted while a result is still pending.
// Region registers should be written only while idle.
module page_frame_bitmap_allocator_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [pfba_pkg::APB_AW-1:0]          paddr,
  input  logic [pfba_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [pfba_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                 pready,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // [2:0] cmd, [34:3] page_addr, [39:35] zero
  input  logic [pfba_pkg::IN_TDATA_W-1:0]      s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [2:0] status, [3] answer, [35:4] frame_addr, [39:36] zero
  output logic [pfba_pkg::OUT_TDATA_W-1:0]     m_tdata
);

  pfba_pkg::geo_t                  geo_b;
  pfba_pkg::geo_t                  geo_a;
  logic                            clear;
  pfba_pkg::mem_req_t              req;
  logic [pfba_pkg::WORD_BITS-1:0]  rdata;
  logic [pfba_pkg::MEM_ROWS-1:0]   full;

  pfba_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .geo_b   (geo_b),
    .geo_a   (geo_a),
    .clear   (clear)
  );

  pfba_map u_map (
    .clk   (clk),
    .rst   (rst),
    .clear (clear),
    .req   (req),
    .rdata (rdata),
    .full  (full)
  );

  pfba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .geo_b    (geo_b),
    .geo_a    (geo_a),
    .req      (req),
    .rdata    (rdata),
    .full     (full)
  );

endmodule
